// ===== rtl/ctsf_pkg.sv =====
// ----------------------------------------------------------------------------
// ctsf_pkg: shared types and constants for the cat text stream filter
// Character codes, register indexes, sequencer phases and the job record
// that goes from the classifier to the expander.
// ----------------------------------------------------------------------------
package ctsf_pkg;

  localparam int NUMBER_DIGITS_DEF = 7;   // BCD digits in the line counter
  localparam int NUM_FIELD_WIDTH   = 6;   // minimum columns of a line number
  localparam int QUEUE_DEPTH_DEF   = 4;   // jobs between front and back

  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] CH_UPPER_I  = 8'h49;
  localparam logic [7:0] CH_UPPER_M  = 8'h4D;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CTRL_MAX    = 8'h1F;
  localparam logic [7:0] CTRL_OFFSET = 8'h40;

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUMBER_NONBLANK  = 3'd0,
    REG_NUMBER_ALL       = 3'd1,
    REG_SQUEEZE_EMPTY    = 3'd2,
    REG_SHOW_TABS        = 3'd3,
    REG_SHOW_NONPRINTING = 3'd4,
    REG_SHOW_ENDS        = 3'd5
  } ctsf_reg_t;

  // Expander phases, in output order
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_NUM,
    PH_TAB,
    PH_MCHAR,
    PH_DASH,
    PH_CARET,
    PH_DOLLAR,
    PH_BODY
  } ctsf_phase_t;

  // One classified input byte: which pieces to print around the body
  typedef struct packed {
    logic       num_en;   // print line number and tab first
    logic       esc_m;    // print "M-"
    logic       caret;    // print '^' before body
    logic       dollar;   // print '$' before body
    logic [7:0] body;     // last character printed
  } ctsf_job_t;

endpackage

// ===== rtl/ctsf_queue.sv =====
// ----------------------------------------------------------------------------
// ctsf_queue: small register FIFO
// Decouples the classifier from the expander; read data is the head entry.
// ----------------------------------------------------------------------------
module ctsf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             q_full,
  output logic             q_valid
);

  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNW-1:0]   count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign rd_data = mem[rd_ptr];
  assign q_full  = (count == CNW'(DEPTH));
  assign q_valid = (count != '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNW'(1);
      end
    end
  end

endmodule

// ===== rtl/ctsf_front.sv =====
// ----------------------------------------------------------------------------
// ctsf_front: option registers and byte classifier
// Tracks line start, blank run and line number; turns each byte that is not squeezed into a job.
// ----------------------------------------------------------------------------
module ctsf_front
  import ctsf_pkg::*;
#(
  parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [7:0]                 in_byte,
  input  logic [7:0]                 next_byte,
  input  logic                       next_present,
  input  logic                       cfg_wr,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic                       cfg_data,
  output logic                       job_push,
  output ctsf_job_t                  job,
  output logic [NUMBER_DIGITS*4-1:0] job_num
);

  localparam int LW = NUMBER_DIGITS * 4;

  logic number_nonblank;
  logic number_all;
  logic squeeze_empty;
  logic show_tabs;
  logic show_nonprinting;
  logic show_ends;

  logic          at_line_start;
  logic [LW-1:0] line_number;
  logic [1:0]    blank_run;

  logic [LW-1:0] line_number_next;
  logic [1:0]    blank_run_next;
  logic          dropped;
  logic          is_lf;
  logic [7:0]    cm;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_nonblank  <= 1'b0;
      number_all       <= 1'b0;
      squeeze_empty    <= 1'b0;
      show_tabs        <= 1'b0;
      show_nonprinting <= 1'b0;
      show_ends        <= 1'b0;
    end else if (cfg_wr) begin
      unique case (ctsf_reg_t'(cfg_index))
        REG_NUMBER_NONBLANK:  number_nonblank  <= cfg_data;
        REG_NUMBER_ALL:       number_all       <= cfg_data;
        REG_SQUEEZE_EMPTY:    squeeze_empty    <= cfg_data;
        REG_SHOW_TABS:        show_tabs        <= cfg_data;
        REG_SHOW_NONPRINTING: show_nonprinting <= cfg_data;
        REG_SHOW_ENDS:        show_ends        <= cfg_data;
        default: ;
      endcase
    end
  end

  // BCD increment, holds at all nines
  always_comb begin
    logic carry;
    logic all_nines;
    line_number_next = line_number;
    carry            = 1'b1;
    all_nines        = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (line_number[i*4 +: 4] != 4'd9) begin
        all_nines = 1'b0;
      end
    end
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry && !all_nines) begin
        if (line_number[i*4 +: 4] == 4'd9) begin
          line_number_next[i*4 +: 4] = 4'd0;
        end else begin
          line_number_next[i*4 +: 4] = line_number[i*4 +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
  end

  // Blank-line squeeze
  always_comb begin
    is_lf          = (in_byte == CH_LF);
    blank_run_next = blank_run;
    dropped        = 1'b0;
    if (squeeze_empty && at_line_start && is_lf) begin
      if (blank_run != 2'd2) begin
        blank_run_next = blank_run + 2'd1;
      end
      dropped = (blank_run_next == 2'd2);
    end else if (!is_lf) begin
      blank_run_next = 2'd0;
    end
  end

  // Job fields
  always_comb begin
    cm          = show_nonprinting ? {1'b0, in_byte[6:0]} : in_byte;
    job.num_en  = at_line_start &&
                  ((number_nonblank && !is_lf) || (number_all && !number_nonblank));
    job.esc_m   = show_nonprinting && in_byte[7];
    job.caret   = 1'b1;
    job.body    = cm;
    if (show_tabs && in_byte == CH_TAB) begin
      job.body = CH_UPPER_I;
    end else if (show_nonprinting && cm == CH_DEL) begin
      job.body = CH_QMARK;
    end else if (show_nonprinting && cm <= CTRL_MAX && cm != CH_LF && cm != CH_TAB) begin
      job.body = cm + CTRL_OFFSET;
    end else if (show_ends && !show_nonprinting && in_byte == CH_CR &&
                 next_present && next_byte == CH_LF) begin
      job.body = CH_UPPER_M;
    end else begin
      job.caret = 1'b0;
    end
    job.dollar = show_ends && (cm == CH_LF);
  end

  assign job_num  = line_number;
  assign job_push = accept && !dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start <= 1'b1;
      line_number   <= LW'(1);
      blank_run     <= 2'd0;
    end else if (accept) begin
      blank_run <= blank_run_next;
      if (!dropped) begin
        at_line_start <= (cm == CH_LF);
        if (job.num_en) begin
          line_number <= line_number_next;
        end
      end
    end
  end

endmodule

// ===== rtl/ctsf_back.sv =====
// ----------------------------------------------------------------------------
// ctsf_back: job expander
// Walks one job through its phases into the output register, one output byte
// per cycle while that register is empty or popped.
// ----------------------------------------------------------------------------
module ctsf_back
  import ctsf_pkg::*;
#(
  parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  ctsf_job_t                  q_job,
  input  logic [NUMBER_DIGITS*4-1:0] q_num,
  output logic                       q_pop,
  input  logic                       pop,
  output logic                       empty,
  output logic [7:0]                 out_byte,
  output logic                       run_end
);

  localparam int LW = NUMBER_DIGITS * 4;
  localparam int CW = $clog2(NUMBER_DIGITS);
  localparam int NW = $clog2(NUMBER_DIGITS + 1);

  ctsf_phase_t   phase;
  ctsf_phase_t   phase_next;
  ctsf_job_t     job;
  logic [LW-1:0] num;
  logic [NW-1:0] ndig;
  logic [CW-1:0] col;
  logic          out_valid;

  logic          adv;
  logic          load;
  logic [NW-1:0] q_ndig;
  logic [NW-1:0] q_cols;
  logic [7:0]    cur_byte;
  logic          cur_end;

  function automatic logic [NW-1:0] ndig_of(input logic [LW-1:0] v);
    logic [NW-1:0] n;
    n = NW'(1);
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (v[i*4 +: 4] != 4'd0) begin
        n = NW'(i + 1);
      end
    end
    return n;
  endfunction

  function automatic ctsf_phase_t after_m(input ctsf_job_t j);
    return j.caret ? PH_CARET : (j.dollar ? PH_DOLLAR : PH_BODY);
  endfunction

  function automatic ctsf_phase_t after_num(input ctsf_job_t j);
    return j.esc_m ? PH_MCHAR : after_m(j);
  endfunction

  function automatic ctsf_phase_t first_phase(input ctsf_job_t j);
    return j.num_en ? PH_NUM : after_num(j);
  endfunction

  assign adv    = (phase != PH_IDLE) && (!out_valid || pop);
  assign load   = q_valid && ((phase == PH_IDLE) || (phase == PH_BODY && adv));
  assign q_pop  = load;
  assign q_ndig = ndig_of(q_num);
  assign q_cols = (q_ndig < NW'(NUM_FIELD_WIDTH)) ? NW'(NUM_FIELD_WIDTH) : q_ndig;

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE:   if (load) phase_next = first_phase(q_job);
      PH_NUM:    if (adv && col == '0) phase_next = PH_TAB;
      PH_TAB:    if (adv) phase_next = after_num(job);
      PH_MCHAR:  if (adv) phase_next = PH_DASH;
      PH_DASH:   if (adv) phase_next = after_m(job);
      PH_CARET:  if (adv) phase_next = PH_BODY;
      PH_DOLLAR: if (adv) phase_next = PH_BODY;
      PH_BODY:   if (adv) phase_next = load ? first_phase(q_job) : PH_IDLE;
      default:   phase_next = PH_IDLE;
    endcase
  end

  // Byte of the current phase
  always_comb begin
    cur_end = (phase == PH_BODY);
    unique case (phase)
      PH_NUM: begin
        if (NW'(col) >= ndig) begin
          cur_byte = CH_SPACE;
        end else begin
          cur_byte = CH_ZERO + {4'd0, num[col*4 +: 4]};
        end
      end
      PH_TAB:    cur_byte = CH_TAB;
      PH_MCHAR:  cur_byte = CH_UPPER_M;
      PH_DASH:   cur_byte = CH_DASH;
      PH_CARET:  cur_byte = CH_CARET;
      PH_DOLLAR: cur_byte = CH_DOLLAR;
      PH_BODY:   cur_byte = job.body;
      default:   cur_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (adv) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job  <= q_job;
      num  <= q_num;
      ndig <= q_ndig;
      col  <= CW'(q_cols - NW'(1));
    end else if (adv && phase == PH_NUM && col != '0) begin
      col <= col - CW'(1);
    end
    if (adv) begin
      out_byte <= cur_byte;
      run_end  <= cur_end;
    end
  end

  assign empty = !out_valid;

endmodule

// ===== rtl/cat_text_stream_filter.sv =====
// ----------------------------------------------------------------------------
// cat_text_stream_filter: streaming text filter with cat -b -n -s -t -v -e
// Byte in, expanded bytes out, with queue-style handshakes on both sides.
// ----------------------------------------------------------------------------
// The filter takes one input transaction per cycle while full is low (in_byte
// plus a look-ahead of the following byte, or next_present low at end of
// stream) and returns the characters cat prints for it, one output transaction
// per byte, with run_end high on the last byte of each input. A numbered line
// start adds up to NUMBER_DIGITS + 1 characters (at least seven), an "M-"
// escape two more, a caret escape or '$' one more. The expander emits one byte
// per cycle while the receiver pops, so sustained output is one byte per cycle
// and input runs at one per cycle while expansions are rare. A QUEUE_DEPTH
// entry job queue sits between the classifier and the expander, so full rises
// only after that many inputs pile up behind a long expansion or a stalled
// pop. An input's job is queued and loaded into the expander before its first
// byte is registered at the output. A squeezed blank line produces no output
// transaction at all. Options are to be written through the cfg channel
// (always ready, bit 0 of cfg_data) only while the filter is idle (not
// enforced); the line counter is BCD, starts at 1 and sticks at all nines.
// ----------------------------------------------------------------------------
module cat_text_stream_filter
  import ctsf_pkg::*;
#(
  parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // input side
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             in_byte,
  input  logic [7:0]             next_byte,
  input  logic                   next_present,
  // result side
  output logic                   empty,
  input  logic                   pop,
  output logic [7:0]             out_byte,
  output logic                   run_end,
  // option registers
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic                   cfg_data
);

  localparam int LW = NUMBER_DIGITS * 4;
  localparam int JW = $bits(ctsf_job_t);
  localparam int QW = JW + LW;

  logic          accept;
  logic          f_push;
  ctsf_job_t     f_job;
  logic [LW-1:0] f_num;

  logic [QW-1:0] q_rdata;
  logic          q_valid;
  logic          q_pop;
  ctsf_job_t     b_job;
  logic [LW-1:0] b_num;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // Front: option registers, line state, classification
  ctsf_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (in_byte),
    .next_byte    (next_byte),
    .next_present (next_present),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .job_push     (f_push),
    .job          (f_job),
    .job_num      (f_num)
  );

  // Job queue; each entry carries the line-number snapshot
  ctsf_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_data ({f_job, f_num}),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .q_full  (full),
    .q_valid (q_valid)
  );

  assign b_job = ctsf_job_t'(q_rdata[QW-1 -: JW]);
  assign b_num = q_rdata[LW-1:0];

  // Back: expansion into output bytes
  ctsf_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_job    (b_job),
    .q_num    (b_num),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .run_end  (run_end)
  );

endmodule

// ===== rtl/ctsf_checker.sv =====
// ----------------------------------------------------------------------------
// ctsf_checker: port-level checks for the cat text stream filter
// Attached to every instance of the top level by the bind below.
// ----------------------------------------------------------------------------
module ctsf_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       run_end,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // Reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("not idle after reset");

  // Option channel never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("cfg channel stalled");

  // Full only rises on an accepted transaction
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without a push");

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(run_end)))
    else $error("waiting result changed");

endmodule

bind cat_text_stream_filter ctsf_checker u_ctsf_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_byte  (out_byte),
  .run_end   (run_end),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

// ===== tb/sv/cat_text_stream_filter_tb.sv =====
// ----------------------------------------------------------------------------
// cat_text_stream_filter_tb: self-checking bench for the cat text filter
// Feeds byte transactions with look-ahead through a queue-driven driver, keeps
// its own expansion of every accepted byte and compares each popped character
// and its run_end flag in order. Option sets go from directed corner cases to
// random text streams with random stalls on both sides.
// ----------------------------------------------------------------------------
module cat_text_stream_filter_tb
  import ctsf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGITS      = NUMBER_DIGITS_DEF;
  localparam int IDLE_PCT    = 17;     // chance per cycle that a side idles
  localparam int HOLD_CYCLES = 120;    // long receiver hold-off
  localparam int TAIL_CYCLES = 12;     // settle time after the last result
  localparam int QUIET_LIMIT = 3000;   // cycles with no transaction at all

  // one input transaction: current byte plus look-ahead
  typedef struct packed {
    logic [7:0] cur;
    logic [7:0] nxt;
    logic       more;
  } text_item_t;

  // one output character
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  logic [7:0]             in_byte = '0;
  logic [7:0]             next_byte = '0;
  logic                   next_present = 1'b0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [7:0]             out_byte;
  logic                   run_end;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic                   cfg_data = 1'b0;

  cat_text_stream_filter u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .next_byte    (next_byte),
    .next_present (next_present),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .run_end      (run_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow state of the filter
  // --------------------------------------------------------------------------
  logic [5:0]          opt = '0;          // indexed by ctsf_reg_t
  logic                at_start = 1'b1;
  logic [4*DIGITS-1:0] line_bcd = 1;
  logic [1:0]          blank_cnt = '0;

  text_item_t  pending_bytes[$];          // items waiting for the driver
  text_char_t  expected_chars[$];         // characters still to be popped
  int unsigned mismatches = 0;

  // Bench-side flags and counters; no_idle and hold_kick change only on the falling edge
  bit no_idle = 1'b0;
  bit hold_kick = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // BCD increment that sticks at all nines
  task automatic bump_line_number();
    bit nines;
    int i;
    nines = 1'b1;
    for (i = 0; i < DIGITS; i++)
      if (line_bcd[4*i +: 4] != 4'd9) nines = 1'b0;
    if (!nines) begin
      for (i = 0; i < DIGITS; i++) begin
        if (line_bcd[4*i +: 4] < 4'd9) begin
          line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
          break;
        end
        line_bcd[4*i +: 4] = 4'd0;
      end
    end
  endtask

  // Expand one accepted byte into the characters cat prints for it
  task automatic expand_text_byte(input logic [7:0] cur, input logic [7:0] nxt,
                                  input logic more);
    logic [7:0] c;
    logic [7:0] chars[$];
    bit dropped;
    bit printed;
    int ndig;
    int width;
    int i;
    c = cur;
    dropped = 1'b0;
    printed = 1'b0;

    // squeeze: count blank lines, drop from the second one on
    if (opt[REG_SQUEEZE_EMPTY] && at_start && c == CH_LF) begin
      if (blank_cnt < 2) blank_cnt = blank_cnt + 2'd1;
      if (blank_cnt > 1) dropped = 1'b1;
    end else if (c != CH_LF) begin
      blank_cnt = '0;
    end

    if (!dropped) begin
      // line number: right-aligned in at least six columns, then a tab
      if (at_start && ((opt[REG_NUMBER_NONBLANK] && c != CH_LF) ||
                       (opt[REG_NUMBER_ALL] && !opt[REG_NUMBER_NONBLANK]))) begin
        ndig = 1;
        for (i = 0; i < DIGITS; i++)
          if (line_bcd[4*i +: 4] != 4'd0) ndig = i + 1;
        width = (ndig < NUM_FIELD_WIDTH) ? NUM_FIELD_WIDTH : ndig;
        for (i = width - 1; i >= 0; i--) begin
          if (i >= ndig) chars.push_back(CH_SPACE);
          else chars.push_back(CH_ZERO + {4'd0, line_bcd[4*i +: 4]});
        end
        chars.push_back(CH_TAB);
        bump_line_number();
      end
      // tab check uses the raw byte, so a high tab stays a tab
      if (opt[REG_SHOW_TABS] && c == CH_TAB) begin
        chars.push_back(CH_CARET);
        chars.push_back(CH_UPPER_I);
        printed = 1'b1;
      end
      if (opt[REG_SHOW_NONPRINTING]) begin
        if (c[7]) begin
          chars.push_back(CH_UPPER_M);
          chars.push_back(CH_DASH);
          c[7] = 1'b0;
        end
        if (c == CH_DEL) begin
          chars.push_back(CH_CARET);
          chars.push_back(CH_QMARK);
          printed = 1'b1;
        end else if (c <= CTRL_MAX && c != CH_LF && c != CH_TAB) begin
          chars.push_back(CH_CARET);
          chars.push_back(c + CTRL_OFFSET);
          printed = 1'b1;
        end
      end
      if (opt[REG_SHOW_ENDS]) begin
        if (c == CH_CR && more && nxt == CH_LF && !opt[REG_SHOW_NONPRINTING]) begin
          chars.push_back(CH_CARET);
          chars.push_back(CH_UPPER_M);
          printed = 1'b1;
        end else if (c == CH_LF) begin
          chars.push_back(CH_DOLLAR);
        end
      end
      if (!printed) chars.push_back(c);
    end

    // a high byte folded to LF under -v also starts a line
    at_start = (c == CH_LF);

    for (i = 0; i < chars.size(); i++)
      expected_chars.push_back('{ch: chars[i], last: (i == chars.size() - 1)});
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents the oldest pending item, holds it while full is high
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!(push && full)) begin
      if (push) begin
        // transaction accepted at this edge
        expand_text_byte(in_byte, next_byte, next_present);
        void'(pending_bytes.pop_front());
      end
      if (pending_bytes.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        push         <= 1'b1;
        in_byte      <= pending_bytes[0].cur;
        next_byte    <= pending_bytes[0].nxt;
        next_present <= pending_bytes[0].more;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: pops results, checks them in order, owns the long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      pop       <= 1'b0;
      hold_left <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected result: out_byte %0h run_end %0b", out_byte, run_end);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (out_byte !== want.ch) begin
            $error("out_byte: expected %0h, actual %0h", want.ch, out_byte);
            mismatches++;
          end
          if (run_end !== want.last) begin
            $error("run_end: expected %0b, actual %0b", want.last, run_end);
            mismatches++;
          end
        end
      end
      if (hold_kick) begin
        hold_left <= HOLD_CYCLES;
        pop       <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else begin
        pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: ends a run that stops moving
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_option(input ctsf_reg_t idx, input logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    opt[idx] = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_options(input logic [5:0] bits);
    int r;
    for (r = 0; r <= REG_SHOW_ENDS; r++)
      write_option(ctsf_reg_t'(r), bits[r]);
  endtask

  // Wait for the sender and the result stream to run dry, then settle;
  // a squeezed line may still be in flight with nothing expected from it
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || push || expected_chars.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic add_byte(input logic [7:0] cur, input logic [7:0] nxt,
                          input logic more);
    pending_bytes.push_back('{cur: cur, nxt: nxt, more: more});
  endtask

  // Well-formed text: the look-ahead is the real next byte, end mark last
  task automatic add_stream(input int n);
    logic [7:0] txt[$];
    int r;
    int k;
    while (txt.size() < n) begin
      r = $urandom_range(99);
      if (r < 18) txt.push_back(CH_LF);
      else if (r < 24) begin
        txt.push_back(CH_CR);
        txt.push_back(CH_LF);
      end
      else if (r < 30) txt.push_back(CH_TAB);
      else if (r < 38) txt.push_back(8'($urandom_range(31)));
      else if (r < 42) txt.push_back(CH_DEL);
      else if (r < 52) txt.push_back(8'($urandom_range(255, 128)));
      else if (r < 56) txt.push_back(($urandom_range(1) != 0) ? (CH_LF | 8'h80)
                                                               : (CH_TAB | 8'h80));
      else txt.push_back(8'($urandom_range(126, 32)));
    end
    for (k = 0; k < txt.size(); k++) begin
      if (k + 1 < txt.size()) add_byte(txt[k], txt[k+1], 1'b1);
      else add_byte(txt[k], 8'($urandom_range(255)), 1'b0);
    end
  endtask

  // Noise: look-ahead unrelated to the stream, end mark at random
  task automatic add_noise(input int n);
    int k;
    for (k = 0; k < n; k++)
      add_byte(8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // -b -n -s -t -e: squeeze, nonblank numbering, CR before LF with and
    // without a following byte, raw DEL and NUL
    set_options(6'b101111);
    @(negedge clk);
    add_byte(CH_LF, CH_LF, 1'b1);
    add_byte(CH_LF, CH_LF, 1'b1);
    add_byte(CH_LF, 8'h41, 1'b1);
    add_byte(8'h41, CH_TAB, 1'b1);
    add_byte(CH_TAB, CH_CR, 1'b1);
    add_byte(CH_CR, CH_LF, 1'b1);
    add_byte(CH_LF, 8'h00, 1'b1);
    add_byte(8'h00, CH_DEL, 1'b1);
    add_byte(CH_DEL, CH_CR, 1'b1);
    add_byte(CH_CR, CH_LF, 1'b0);
    add_byte(CH_LF, 8'hFF, 1'b0);
    wait_drained();

    // -n -t -v -e: caret and M- escapes, high tab and high LF
    set_options(6'b111010);
    @(negedge clk);
    add_byte(8'h00, 8'h1F, 1'b1);
    add_byte(CTRL_MAX, CH_DEL, 1'b1);
    add_byte(CH_DEL, 8'hFF, 1'b1);
    add_byte(8'hFF, 8'h80, 1'b1);
    add_byte(8'h80, CH_TAB | 8'h80, 1'b1);
    add_byte(CH_TAB | 8'h80, CH_LF | 8'h80, 1'b1);
    add_byte(CH_LF | 8'h80, CH_CR, 1'b1);
    add_byte(CH_CR, CH_LF, 1'b1);
    add_byte(CH_LF, CH_TAB, 1'b1);
    add_byte(CH_TAB, CH_LF, 1'b1);
    add_byte(CH_LF, 8'h41, 1'b1);
    add_byte(8'h41, 8'h00, 1'b0);
    wait_drained();

    // all options off
    set_options(6'b000000);
    @(negedge clk);
    add_stream(38);
    add_noise(7);
    wait_drained();

    // all options on, with the receiver holding off so the input backs up
    set_options(6'b111111);
    @(negedge clk);
    add_stream(38);
    add_noise(7);
    hold_kick = 1'b1;
    @(negedge clk);
    hold_kick = 1'b0;
    wait_drained();

    // random options, sender pauses midway until everything is out
    set_options(6'($urandom_range(63)));
    @(negedge clk);
    add_stream(20);
    wait_drained();
    @(negedge clk);
    add_stream(20);
    add_noise(5);
    wait_drained();

    // random options, back to back on both sides
    set_options(6'($urandom_range(63)));
    @(negedge clk);
    no_idle = 1'b1;
    add_stream(40);
    add_noise(5);
    wait_drained();
    @(negedge clk);
    no_idle = 1'b0;

    // two more random settings
    repeat (2) begin
      set_options(6'($urandom_range(63)));
      @(negedge clk);
      add_stream(38);
      add_noise(7);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
